@@ hw/rtl/nalfrag_pkg.sv @@
// Shared types and constants for the H.264 NAL to RTP FU-A fragmenter.
// No dependencies; used by every module under hw/rtl.
package nalfrag_pkg;

    localparam int SIZE_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [13:0] MAX_PAYLOAD_RESET = 14'd1400;
    localparam logic [31:0] TS_STEP_RESET     = 32'd3000;
    localparam logic [13:0] MAX_PAYLOAD_MIN   = 14'd16;
    localparam logic [13:0] MAX_PAYLOAD_MAX   = 14'd8192;

    localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
    localparam logic [4:0] NAL_TYPE_PPS = 5'd8;
    localparam logic [4:0] FU_A_TYPE    = 5'd28;

    localparam logic REG_MAX_PAYLOAD = 1'b0;
    localparam logic REG_TS_STEP     = 1'b1;

    // One queued entry: everything the back end needs for one accepted byte.
    typedef struct packed {
        logic [7:0]  data;
        logic        data_first;
        logic        data_last;
        logic        has_fu;
        logic [7:0]  fu_ind;
        logic [7:0]  fu_hdr;
        logic [15:0] seq;
        logic [31:0] stamp;
    } job_t;

    typedef enum logic [1:0] {
        BK_LEAD,
        BK_FUHDR,
        BK_DATA
    } bk_state_t;

endpackage

@@ hw/rtl/h264_nal_rtp_fragmenter.sv @@
// H.264 NAL to RTP payload fragmenter (FU-A), top level with APB config registers.
// Depends on nalfrag_pkg, nalfrag_front, nalfrag_queue and nalfrag_back.
//
// Usage:
//   Input channel (in_valid/in_stall): one NAL byte per transfer, header byte first;
//   nal_size is sampled on the first byte of each NAL.
//   Output channel (out_valid/out_stall): one payload byte per transfer, with packet
//   first/last flags, sequence number and timestamp; run_last marks the final byte
//   produced by an input byte. The header byte of a fragmented NAL produces nothing;
//   the first byte of each fragment produces three (FU indicator, FU header, data).
//   Throughput: one input transfer per cycle while in_stall is low; output runs at
//   one byte per cycle while out_stall is low, so the two extra bytes of each
//   fragment start are taken up by the job queue.
//   in_stall rises when the QUEUE_DEPTH-entry job queue is full, which happens only
//   while out_stall holds the output register or after fragment starts.
//   Reset clears counters, queue and output valid; max_payload returns to 1400 and
//   timestamp_step to 3000. Write registers only while the block is idle.
//   Registers: 0x0 max_payload (14 bits, clamped to 16..8192), 0x4 timestamp_step.
module h264_nal_rtp_fragmenter #(
    parameter int SIZE_BITS   = nalfrag_pkg::SIZE_BITS,
    parameter int QUEUE_DEPTH = nalfrag_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           nal_byte,
    input  logic [SIZE_BITS-1:0] nal_size,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_byte,
    output logic                 packet_first,
    output logic                 packet_last,
    output logic [15:0]          sequence_res,
    output logic [31:0]          stamp,
    output logic                 run_last
);

    logic [13:0] max_payload_reg;
    logic [31:0] ts_step_reg;
    logic        wr_en;

    logic              accept;
    logic              push, pop, q_empty, q_full;
    nalfrag_pkg::job_t push_job, head;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= nalfrag_pkg::MAX_PAYLOAD_RESET;
            ts_step_reg     <= nalfrag_pkg::TS_STEP_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == nalfrag_pkg::REG_TS_STEP)
            begin
                ts_step_reg <= pwdata;
            end
            else
            begin
                max_payload_reg <= pwdata[13:0];
            end
        end
    end

    assign prdata = (paddr[2] == nalfrag_pkg::REG_TS_STEP) ? ts_step_reg
                                                           : {18'd0, max_payload_reg};

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    nalfrag_front #(
        .SIZE_BITS(SIZE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .nal_byte       (nal_byte),
        .nal_size       (nal_size),
        .max_payload    (max_payload_reg),
        .timestamp_step (ts_step_reg),
        .push           (push),
        .job            (push_job)
    );

    nalfrag_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .empty    (q_empty),
        .full     (q_full)
    );

    nalfrag_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .packet_first (packet_first),
        .packet_last  (packet_last),
        .sequence_res (sequence_res),
        .stamp        (stamp),
        .run_last     (run_last)
    );

endmodule

@@ hw/rtl/nalfrag_front.sv @@
// Front end: accepts NAL bytes, tracks NAL/chunk position, sequence and timestamp,
// and builds one queue entry per byte that produces output. Uses nalfrag_pkg.
module nalfrag_front #(
    parameter int SIZE_BITS = nalfrag_pkg::SIZE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [7:0]            nal_byte,
    input  logic [SIZE_BITS-1:0]  nal_size,
    input  logic [13:0]           max_payload,
    input  logic [31:0]           timestamp_step,
    output logic                  push,
    output nalfrag_pkg::job_t     job
);

    localparam int CW = ((SIZE_BITS > 14) ? SIZE_BITS : 14) + 2;

    logic [SIZE_BITS-1:0] byte_index_reg, byte_index_next;
    logic [12:0]          chunk_fill_reg, chunk_fill_next;
    logic [SIZE_BITS-1:0] held_size_reg, held_size_next;
    logic [7:0]           held_header_reg;
    logic                 fragmenting_reg, fragmenting_next;
    logic [15:0]          seq_count_reg, seq_count_next;
    logic [31:0]          time_count_reg, time_count_next;

    logic [13:0]          m;
    logic                 first;
    logic [SIZE_BITS-1:0] sz;
    logic [SIZE_BITS-1:0] eff_size;
    logic [7:0]           eff_hdr;
    logic                 frag_now;
    logic [CW-1:0]        bi_w, m_w, d, dn, cf_w;
    logic                 last_np, lone, end_pkt, nal_end, frag_e;
    logic                 param_set;

    always_comb
    begin
        if (max_payload < nalfrag_pkg::MAX_PAYLOAD_MIN)
        begin
            m = nalfrag_pkg::MAX_PAYLOAD_MIN;
        end
        else if (max_payload > nalfrag_pkg::MAX_PAYLOAD_MAX)
        begin
            m = nalfrag_pkg::MAX_PAYLOAD_MAX;
        end
        else
        begin
            m = max_payload;
        end
    end

    assign first    = (byte_index_reg == '0);
    assign sz       = (nal_size == '0) ? SIZE_BITS'(1) : nal_size;
    assign eff_size = first ? sz : held_size_reg;
    assign eff_hdr  = first ? nal_byte : held_header_reg;
    assign m_w      = CW'(m);
    assign frag_now = first ? (CW'(sz) > m_w) : fragmenting_reg;
    assign bi_w     = CW'(byte_index_reg);
    assign last_np  = (bi_w + CW'(1)) >= CW'(eff_size);

    assign d       = bi_w - CW'(1);
    assign dn      = CW'(held_size_reg) - CW'(1);
    assign cf_w    = CW'(chunk_fill_reg);
    assign lone    = (d == '0) && (dn == m_w);
    assign nal_end = (d + CW'(1)) >= dn;
    assign end_pkt = nal_end || ((cf_w + CW'(1)) >= m_w) ||
                     ((dn == m_w) && ((d + CW'(2)) == m_w));
    assign frag_e  = ((dn - d) <= m_w) && !lone;

    assign param_set = (eff_hdr[4:0] == nalfrag_pkg::NAL_TYPE_SPS) ||
                       (eff_hdr[4:0] == nalfrag_pkg::NAL_TYPE_PPS);

    always_comb
    begin
        byte_index_next  = byte_index_reg;
        chunk_fill_next  = chunk_fill_reg;
        held_size_next   = held_size_reg;
        fragmenting_next = fragmenting_reg;
        seq_count_next   = seq_count_reg;
        time_count_next  = time_count_reg;
        push             = 1'b0;

        job.data       = nal_byte;
        job.data_first = first;
        job.data_last  = last_np;
        job.has_fu     = 1'b0;
        job.fu_ind     = {1'b0, eff_hdr[6:5], nalfrag_pkg::FU_A_TYPE};
        job.fu_hdr     = {(d == '0), frag_e, 1'b0, eff_hdr[4:0]};
        job.seq        = seq_count_reg;
        job.stamp      = time_count_reg;

        if (accept)
        begin
            if (first)
            begin
                held_size_next   = sz;
                fragmenting_next = frag_now;
                chunk_fill_next  = '0;
            end

            if (first && frag_now)
            begin
                byte_index_next = SIZE_BITS'(1);
            end
            else if (!frag_now)
            begin
                push = 1'b1;
                if (last_np)
                begin
                    seq_count_next  = seq_count_reg + 16'd1;
                    byte_index_next = '0;
                    if (!param_set)
                    begin
                        time_count_next = time_count_reg + timestamp_step;
                    end
                end
                else
                begin
                    byte_index_next = byte_index_reg + SIZE_BITS'(1);
                end
            end
            else
            begin
                push           = 1'b1;
                job.data_first = (chunk_fill_reg != '0);
                job.data_last  = end_pkt;
                job.has_fu     = (chunk_fill_reg == '0);
                if (end_pkt)
                begin
                    seq_count_next  = seq_count_reg + 16'd1;
                    chunk_fill_next = '0;
                end
                else
                begin
                    chunk_fill_next = chunk_fill_reg + 13'd1;
                end
                if (nal_end)
                begin
                    byte_index_next  = '0;
                    fragmenting_next = 1'b0;
                    chunk_fill_next  = '0;
                    time_count_next  = time_count_reg + timestamp_step;
                end
                else
                begin
                    byte_index_next = byte_index_reg + SIZE_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= '0;
            chunk_fill_reg  <= '0;
            held_size_reg   <= '0;
            fragmenting_reg <= 1'b0;
            seq_count_reg   <= '0;
            time_count_reg  <= '0;
        end
        else
        begin
            byte_index_reg  <= byte_index_next;
            chunk_fill_reg  <= chunk_fill_next;
            held_size_reg   <= held_size_next;
            fragmenting_reg <= fragmenting_next;
            seq_count_reg   <= seq_count_next;
            time_count_reg  <= time_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && first)
        begin
            held_header_reg <= nal_byte;
        end
    end

endmodule

@@ hw/rtl/nalfrag_queue.sv @@
// Short FIFO of job entries between the front and back ends.
// Uses nalfrag_pkg::job_t.
module nalfrag_queue #(
    parameter int DEPTH = nalfrag_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nalfrag_pkg::job_t push_job,
    input  logic              pop,
    output nalfrag_pkg::job_t head,
    output logic              empty,
    output logic              full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    nalfrag_pkg::job_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == NW'(DEPTH));
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(DEPTH))
        else $error("queue count above depth");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
`endif

endmodule

@@ hw/rtl/nalfrag_back.sv @@
// Back end: expands each queued job into one or three payload bytes
// (FU indicator, FU header, data) in an output register. Uses nalfrag_pkg.
module nalfrag_back (
    input  logic              clk,
    input  logic              rst_n,
    input  nalfrag_pkg::job_t head,
    input  logic              q_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              packet_first,
    output logic              packet_last,
    output logic [15:0]       sequence_res,
    output logic [31:0]       stamp,
    output logic              run_last
);

    nalfrag_pkg::bk_state_t state_reg, state_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic        first_reg, last_reg, run_last_reg;
    logic [15:0] seq_reg;
    logic [31:0] stamp_reg;

    logic        load, take;
    logic [7:0]  res_byte;
    logic        res_first, res_last, res_run_last;

    assign load = !out_valid_reg || !out_stall;
    assign take = load && !q_empty;

    always_comb
    begin
        state_next     = state_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = !q_empty;
        end
        if (take)
        begin
            case (state_reg)
                nalfrag_pkg::BK_LEAD:
                begin
                    if (head.has_fu)
                    begin
                        state_next = nalfrag_pkg::BK_FUHDR;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                nalfrag_pkg::BK_FUHDR:
                begin
                    state_next = nalfrag_pkg::BK_DATA;
                end
                nalfrag_pkg::BK_DATA:
                begin
                    pop        = 1'b1;
                    state_next = nalfrag_pkg::BK_LEAD;
                end
                default:
                begin
                    state_next = nalfrag_pkg::BK_LEAD;
                end
            endcase
        end
    end

    always_comb
    begin
        res_byte     = head.data;
        res_first    = head.data_first;
        res_last     = head.data_last;
        res_run_last = 1'b1;
        case (state_reg)
            nalfrag_pkg::BK_LEAD:
            begin
                if (head.has_fu)
                begin
                    res_byte     = head.fu_ind;
                    res_first    = 1'b1;
                    res_last     = 1'b0;
                    res_run_last = 1'b0;
                end
            end
            nalfrag_pkg::BK_FUHDR:
            begin
                res_byte     = head.fu_hdr;
                res_first    = 1'b0;
                res_last     = 1'b0;
                res_run_last = 1'b0;
            end
            nalfrag_pkg::BK_DATA:
            begin
                res_first = 1'b0;
            end
            default:
            begin
                res_byte = head.data;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nalfrag_pkg::BK_LEAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg     <= res_byte;
            first_reg    <= res_first;
            last_reg     <= res_last;
            run_last_reg <= res_run_last;
            seq_reg      <= head.seq;
            stamp_reg    <= head.stamp;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = byte_reg;
    assign packet_first = first_reg;
    assign packet_last  = last_reg;
    assign sequence_res = seq_reg;
    assign stamp        = stamp_reg;
    assign run_last     = run_last_reg;

`ifndef SYNTHESIS
    a_fuhdr_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != nalfrag_pkg::BK_LEAD) |-> !q_empty)
        else $error("mid-job state with empty queue");
    a_pop_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && run_last))
        else $error("job popped without final byte");
    a_hdr_after_ind: assert property (@(posedge clk) disable iff (!rst_n)
        (take && state_reg == nalfrag_pkg::BK_FUHDR) |=> (!packet_first && !run_last))
        else $error("FU header byte flagged wrong");
`endif

endmodule

@@ dv/nalfrag_checker.sv @@
// Checker for the NAL to RTP FU-A fragmenter: watches the APB port and both channels,
// predicts every payload byte and compares it field by field with the block's output.
// Depends on nalfrag_pkg for register indexes, NAL types and reset values.
module nalfrag_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  nal_byte,
    input  logic [15:0] nal_size,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  out_byte,
    input  logic        packet_first,
    input  logic        packet_last,
    input  logic [15:0] sequence_res,
    input  logic [31:0] stamp,
    input  logic        run_last,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_MAX_PAYLOAD = {nalfrag_pkg::REG_MAX_PAYLOAD, 2'b00};
    localparam logic [2:0] ADDR_TS_STEP     = {nalfrag_pkg::REG_TS_STEP, 2'b00};
    localparam logic [7:0] FU_S_BIT         = 8'h80;
    localparam logic [7:0] FU_E_BIT         = 8'h40;
    localparam logic [7:0] NRI_MASK         = 8'h60;

    typedef struct packed {
        logic [7:0]  data;
        logic        pkt_first;
        logic        pkt_last;
        logic [15:0] seq;
        logic [31:0] ts;
        logic        run_end;
    } payload_t;

    payload_t    payload_q[$];

    logic [13:0] max_payload_reg = nalfrag_pkg::MAX_PAYLOAD_RESET;
    logic [31:0] ts_step_reg     = nalfrag_pkg::TS_STEP_RESET;
    logic [15:0] byte_idx        = '0;
    logic [12:0] chunk_fill      = '0;
    logic [15:0] nal_len         = '0;
    logic [7:0]  nal_hdr         = '0;
    logic        fragmenting     = 1'b0;
    logic [15:0] seq_num         = '0;
    logic [31:0] ts_now          = '0;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("[%0t] %s mismatch: got 0x%0h, want 0x%0h", $time, field, got, want);
        fail_count++;
    endtask

    task automatic emit(input logic [7:0] v, input logic f, input logic l, input logic r);
        payload_q.push_back('{v, f, l, seq_num, ts_now, r});
    endtask

    // Bytes that one accepted NAL byte turns into.
    task automatic packetize(input logic [7:0] b, input logic [15:0] sz);
        int unsigned m;
        int unsigned d;
        int unsigned dn;
        logic [15:0] s;
        logic [7:0]  fh;
        logic        lone;
        logic        end_pkt;
        logic        last;
        int          n;
        m = 32'(max_payload_reg);
        if (m < nalfrag_pkg::MAX_PAYLOAD_MIN)
            m = 32'(nalfrag_pkg::MAX_PAYLOAD_MIN);
        if (m > nalfrag_pkg::MAX_PAYLOAD_MAX)
            m = 32'(nalfrag_pkg::MAX_PAYLOAD_MAX);
        n = 0;
        if (byte_idx == 0)
        begin
            s = (sz == 0) ? 16'd1 : sz;
            nal_len     = s;
            nal_hdr     = b;
            fragmenting = s > m;
            chunk_fill  = '0;
            if (fragmenting)
            begin
                byte_idx = 16'd1;
                return;
            end
        end
        if (!fragmenting)
        begin
            last = byte_idx + 1 >= nal_len;
            emit(b, byte_idx == 0, last, 1'b1);
            if (last)
            begin
                seq_num++;
                if (nal_hdr[4:0] != nalfrag_pkg::NAL_TYPE_SPS &&
                    nal_hdr[4:0] != nalfrag_pkg::NAL_TYPE_PPS)
                    ts_now += ts_step_reg;
                byte_idx = '0;
            end
            else
                byte_idx++;
            return;
        end
        d  = byte_idx - 1;
        dn = nal_len - 1;
        if (chunk_fill == 0)
        begin
            fh   = {3'b000, nal_hdr[4:0]};
            lone = (d == 0) && (dn == m);
            if (d == 0)
                fh |= FU_S_BIT;
            if (dn - d <= m && !lone)
                fh |= FU_E_BIT;
            emit((nal_hdr & NRI_MASK) | {3'b000, nalfrag_pkg::FU_A_TYPE}, 1'b1, 1'b0, 1'b0);
            emit(fh, 1'b0, 1'b0, 1'b0);
            n = 2;
        end
        end_pkt = (d + 1 >= dn) || (chunk_fill + 1 >= m) || (dn == m && d + 2 == m);
        emit(b, n == 0, end_pkt, 1'b1);
        if (end_pkt)
        begin
            seq_num++;
            chunk_fill = '0;
        end
        else
            chunk_fill++;
        if (d + 1 >= dn)
        begin
            byte_idx    = '0;
            fragmenting = 1'b0;
            chunk_fill  = '0;
            ts_now += ts_step_reg;
        end
        else
            byte_idx++;
    endtask

    task automatic check_transfer();
        payload_t want;
        if (payload_q.size() == 0)
        begin
            report("unexpected transfer, out_byte", 32'(out_byte), 32'd0);
            return;
        end
        want = payload_q.pop_front();
        if (out_byte !== want.data)
            report("out_byte", 32'(out_byte), 32'(want.data));
        if (packet_first !== want.pkt_first)
            report("packet_first", 32'(packet_first), 32'(want.pkt_first));
        if (packet_last !== want.pkt_last)
            report("packet_last", 32'(packet_last), 32'(want.pkt_last));
        if (sequence_res !== want.seq)
            report("sequence_res", 32'(sequence_res), 32'(want.seq));
        if (stamp !== want.ts)
            report("stamp", stamp, want.ts);
        if (run_last !== want.run_end)
            report("run_last", 32'(run_last), 32'(want.run_end));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_q.delete();
            max_payload_reg = nalfrag_pkg::MAX_PAYLOAD_RESET;
            ts_step_reg     = nalfrag_pkg::TS_STEP_RESET;
            byte_idx        = '0;
            chunk_fill      = '0;
            nal_len         = '0;
            fragmenting     = 1'b0;
            seq_num         = '0;
            ts_now          = '0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_transfer();
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == ADDR_MAX_PAYLOAD)
                    max_payload_reg = pwdata[13:0];
                else if (paddr == ADDR_TS_STEP)
                    ts_step_reg = pwdata;
            end
            if (in_valid && !in_stall)
                packetize(nal_byte, nal_size);
        end
        pending = payload_q.size();
    end

endmodule

@@ dv/testbench.sv @@
// Top of the fragmenter testbench: clock, reset, APB writes, NAL byte stimulus and
// output stalls; the verdict comes from the failure and pending counts of nalfrag_checker.
// Depends on nalfrag_pkg, nalfrag_checker and h264_nal_rtp_fragmenter.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ADDR_MAX_PAYLOAD = {nalfrag_pkg::REG_MAX_PAYLOAD, 2'b00};
    localparam logic [2:0] ADDR_TS_STEP     = {nalfrag_pkg::REG_TS_STEP, 2'b00};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  nal_byte  = '0;
    logic [15:0] nal_size  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        packet_first;
    logic        packet_last;
    logic [15:0] sequence_res;
    logic [31:0] stamp;
    logic        run_last;
    int          fail_count;
    int          pending;

    int unsigned cur_limit   = 1400;
    int          burst_left  = 0;
    int          nal_left    = 0;
    logic        nal_first   = 1'b0;
    logic [7:0]  gen_hdr     = '0;
    logic [15:0] gen_size    = '0;
    int          stall_cyc   = 0;
    int          stall_mode  = 0;

    h264_nal_rtp_fragmenter uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .nal_byte(nal_byte), .nal_size(nal_size),
        .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
        .packet_first(packet_first), .packet_last(packet_last),
        .sequence_res(sequence_res), .stamp(stamp), .run_last(run_last)
    );

    nalfrag_checker chk (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_stall(in_stall), .nal_byte(nal_byte), .nal_size(nal_size),
        .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
        .packet_first(packet_first), .packet_last(packet_last),
        .sequence_res(sequence_res), .stamp(stamp), .run_last(run_last),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver stall pattern; heavy mode backs up the job queue.
    always @(posedge clk)
    begin
        stall_cyc++;
        if (stall_cyc % 61 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            2: out_stall <= (stall_cyc % 8) < 5;
            default: out_stall <= ((stall_cyc / 8) % 2) == 1;
        endcase
    end

    function automatic int unsigned payload_limit(input logic [13:0] v);
        if (v < nalfrag_pkg::MAX_PAYLOAD_MIN)
            return 32'(nalfrag_pkg::MAX_PAYLOAD_MIN);
        if (v > nalfrag_pkg::MAX_PAYLOAD_MAX)
            return 32'(nalfrag_pkg::MAX_PAYLOAD_MAX);
        return 32'(v);
    endfunction

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [15:0] sz);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        nal_byte <= b;
        nal_size <= sz;
        do @(posedge clk); while (in_stall);
    endtask

    // Sender holds off until every predicted byte has been transferred.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_config(input logic [13:0] maxp, input logic [31:0] step);
        settle();
        apb_write(ADDR_MAX_PAYLOAD, {18'b0, maxp});
        apb_write(ADDR_TS_STEP, step);
        cur_limit = payload_limit(maxp);
    endtask

    task automatic start_nal();
        int unsigned m;
        int unsigned len;
        int          pick;
        logic [7:0]  hdr;
        m    = cur_limit;
        pick = $urandom_range(0, 9);
        if (m > 64)
            len = (pick == 0) ? 0 : $urandom_range(1, 48);
        else
            case (pick)
                0: len = 0;
                1: len = 1;
                2, 3: len = $urandom_range(2, m);
                4: len = m;
                5: len = m + 1;
                6: len = m + 2;
                7, 8: len = $urandom_range(m + 3, 3 * m);
                default: len = 2 * m + 1;
            endcase
        hdr = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            hdr[4:0] = $urandom_range(0, 1) ? nalfrag_pkg::NAL_TYPE_SPS
                                            : nalfrag_pkg::NAL_TYPE_PPS;
        gen_hdr   = hdr;
        gen_size  = 16'(len);
        nal_left  = (len == 0) ? 1 : len;
        nal_first = 1'b1;
    endtask

    // NALs run on across calls, so register changes can land mid-NAL.
    task automatic feed(input int count);
        repeat (count)
        begin
            if (nal_left == 0)
                start_nal();
            if (nal_first)
                send_byte(gen_hdr, gen_size);
            else
                send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            nal_first = 1'b0;
            nal_left--;
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_byte(8'hFF, 16'd0);
        send_byte(8'h67, 16'd1);
        send_byte(8'h68, 16'd2);
        send_byte(8'hAA, 16'hFFFF);
        send_byte(8'h01, 16'd3);
        send_byte(8'h00, 16'h0000);
        send_byte(8'hFF, 16'h5A5A);

        set_config(nalfrag_pkg::MAX_PAYLOAD_MIN, 32'hFFFF_FFFF);
        send_byte(8'h65, 16'd17);
        repeat (16) send_byte(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_config(14'd0, $urandom());
                1: set_config(14'($urandom_range(17, 40)), 32'd0);
                2: set_config(14'h3FFF, 32'hFFFF_FFFF);
                3: set_config(nalfrag_pkg::MAX_PAYLOAD_MAX, $urandom());
                4: set_config(nalfrag_pkg::MAX_PAYLOAD_MIN, $urandom_range(1, 90000));
                default: set_config(nalfrag_pkg::MAX_PAYLOAD_RESET, nalfrag_pkg::TS_STEP_RESET);
            endcase
            feed(45);
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
